[rtl/rrec_pkg.sv]
// Package for the raster road edge cost block.
// Holds sizes, configuration codes, sequencer states and edge slot codes.
// It has no dependencies; every other file refers to it by scoped names.
package rrec_pkg;

   // Raster limits and the widths that follow from them.
   localparam int MAX_COLS = 4096;
   localparam int MAX_ROWS = 65536;
   localparam int COL_W    = $clog2(MAX_COLS);
   localparam int ROW_W    = $clog2(MAX_ROWS);

   // Field and register widths.
   localparam int CFG_COLS_W = 13;
   localparam int CSR_DATA_W = 32;
   localparam int SPEED_W    = 8;
   localparam int ID_W       = 29;
   localparam int COST_W     = 32;
   localparam int SUM_W      = SPEED_W + 1;
   localparam int DVD_W      = COST_W + 1;

   // Speed code for a cell without a road.
   localparam logic [SPEED_W-1:0] NO_ROAD = 8'hFF;

   // Square root of two as unsigned Q1.30.
   localparam int                SQRT2_FRAC = 30;
   localparam logic [30:0]       SQRT2_Q30  = 31'd1518500250;

   // Register reset values.
   localparam logic [CFG_COLS_W-1:0] NUM_COLUMNS_RST = 13'd4096;
   localparam logic [COST_W-1:0]     TIME_SCALE_RST  = 32'd65536;

   // Saturated cost.
   localparam logic [COST_W-1:0] COST_ONES = '1;

   // Configuration register indexes.
   typedef enum logic [0:0] {
      CSR_NUM_COLUMNS = 1'b0,
      CSR_TIME_SCALE  = 1'b1
   } csr_index_type;

   // Neighbor slots in emission order.
   typedef enum logic [1:0] {
      SLOT_NW = 2'd0,
      SLOT_N  = 2'd1,
      SLOT_NE = 2'd2,
      SLOT_W  = 2'd3
   } edge_slot_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_SETUP,
      ST_PICK,
      ST_DIV,
      ST_EMIT
   } seq_state_type;

endpackage

[rtl/rrec_if.sv]
// Channel interfaces of the raster road edge cost block.
// One interface carries a cell request, the other an edge result.
// Depends on rrec_pkg for the field widths.
interface rrec_req_if;
   logic                         valid;
   logic                         ready;
   logic [rrec_pkg::SPEED_W-1:0] speed;
   logic                         frame_start;

   modport source(output valid, speed, frame_start, input ready);
   modport sink(input valid, speed, frame_start, output ready);
endinterface

interface rrec_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [rrec_pkg::ID_W-1:0]   from_id;
   logic [rrec_pkg::ID_W-1:0]   to_id;
   logic [rrec_pkg::COST_W-1:0] cost;
   logic                        last_of_cell;

   modport source(output valid, from_id, to_id, cost, last_of_cell, input ready);
   modport sink(input valid, from_id, to_id, cost, last_of_cell, output ready);
endinterface

[rtl/raster_road_edge_cost.sv]
// Top level of the raster road edge cost block.
// Uses rrec_pkg, the channel interfaces in rrec_if and the serial divider rrec_div.
//
// Usage: road-speed cells arrive on req_bus in row-major order, one request per
// cell; frame_start marks the first cell of a raster. For each road cell the block
// sends one rsp_bus result per road neighbor, in the order north-west, north,
// north-east, west, with last_of_cell set on the final one. Cells without a road,
// or without road neighbors, produce no result.
// csr_wr_en with csr_index and csr_wdata writes num_columns (index 0) or
// time_scale (index 1); write only while no cell is in progress.
// Timing: req_bus.ready is high only while the sequencer is idle. A cell passes
// through acceptance, line-buffer read and setup; each divided edge then runs the
// serial divider over 33 quotient bits, a zero-sum edge goes straight to emit, and
// each skipped slot is passed over in the pick state.
// Results pass through an output register: a stalled receiver holds the current
// result and the sequencer waits before loading the next, but the block takes a
// new cell once the last result of a cell is in that register.
// Reset (synchronous) restores num_columns 4096, time_scale 1.0, row and column
// zero and clears the output; the line buffer is not cleared.
module raster_road_edge_cost (
   input  logic                                clock,
   input  logic                                reset,
   rrec_req_if.sink                            req_bus,
   rrec_rsp_if.source                          rsp_bus,
   input  logic                                csr_wr_en,
   input  rrec_pkg::csr_index_type             csr_index,
   input  logic [rrec_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int WID_W = rrec_pkg::COL_W + 1;
   localparam int PRD_W = 2 * rrec_pkg::COST_W;

   // Configuration registers.
   logic [rrec_pkg::CFG_COLS_W-1:0] num_cols_ff;
   logic [rrec_pkg::COST_W-1:0]     ts_ff;

   // Sequencer state.
   rrec_pkg::seq_state_type state_ff, state_in;
   rrec_pkg::edge_slot_type slot_ff, last_ff, last_c;
   logic [3:0]              mask_ff, mask_c;

   // Raster position and neighbor history.
   logic [rrec_pkg::COL_W-1:0]   col_ff;
   logic [rrec_pkg::ROW_W-1:0]   row_ff;
   logic [rrec_pkg::SPEED_W-1:0] left_ff, diag_ff, s_ff;
   logic [rrec_pkg::SPEED_W-1:0] n_rd_ff, ne_rd_ff;
   logic [rrec_pkg::SPEED_W-1:0] nb_ff [4];
   logic                         start_ff;

   // Line buffer holding the previous row.
   logic [rrec_pkg::SPEED_W-1:0] row_mem [rrec_pkg::MAX_COLS];

   // Id and cost datapath.
   logic [rrec_pkg::ID_W-1:0]   base_ff, me_c_ff, up_c_ff;
   logic [rrec_pkg::DVD_W-1:0]  diag_prod_ff;
   logic [rrec_pkg::COST_W-1:0] cost_ff;
   logic [PRD_W-1:0]            prod_c;

   // Output register.
   logic                        rsp_valid_ff;
   logic [rrec_pkg::ID_W-1:0]   rsp_from_ff, rsp_to_ff;
   logic [rrec_pkg::COST_W-1:0] rsp_cost_ff;
   logic                        rsp_last_ff;

   // Combinational helpers.
   logic [WID_W-1:0]           width_c;
   logic [WID_W-1:0]           col_plus1;
   logic [rrec_pkg::ROW_W-1:0] row_inc;
   logic [rrec_pkg::SUM_W-1:0] sum_c;
   logic [rrec_pkg::DVD_W-1:0] dividend_c;
   logic [rrec_pkg::ID_W-1:0]  to_id_c;
   logic                       is_diag;
   logic                       accept;
   logic                       out_free;
   logic                       out_load;
   logic                       div_start;
   logic                       div_busy;
   logic                       div_done;
   logic [rrec_pkg::COST_W-1:0] div_quot;

   // Effective raster width, clamped into one to the line buffer depth.
   always_comb begin
      if (num_cols_ff == '0) begin
         width_c = WID_W'(1);
      end else if (num_cols_ff > rrec_pkg::CFG_COLS_W'(rrec_pkg::MAX_COLS)) begin
         width_c = WID_W'(rrec_pkg::MAX_COLS);
      end else begin
         width_c = WID_W'(num_cols_ff);
      end
   end

   assign col_plus1 = {1'b0, col_ff} + WID_W'(1);
   assign row_inc   = (row_ff == rrec_pkg::ROW_W'(rrec_pkg::MAX_ROWS - 1)) ? '0
                                                                          : row_ff + 1'b1;

   // Which neighbors get an edge, decided once the line buffer data is in.
   always_comb begin
      logic road, r_pos, c_pos, c_more;
      road      = (s_ff != rrec_pkg::NO_ROAD);
      r_pos     = (row_ff != '0);
      c_pos     = (col_ff != '0);
      c_more    = (col_plus1 < width_c);
      mask_c[0] = road && r_pos && c_pos && (diag_ff != rrec_pkg::NO_ROAD);
      mask_c[1] = road && r_pos && (n_rd_ff != rrec_pkg::NO_ROAD);
      mask_c[2] = road && r_pos && c_more && (ne_rd_ff != rrec_pkg::NO_ROAD);
      mask_c[3] = road && c_pos && (left_ff != rrec_pkg::NO_ROAD);
      if (mask_c[3]) begin
         last_c = rrec_pkg::SLOT_W;
      end else if (mask_c[2]) begin
         last_c = rrec_pkg::SLOT_NE;
      end else if (mask_c[1]) begin
         last_c = rrec_pkg::SLOT_N;
      end else begin
         last_c = rrec_pkg::SLOT_NW;
      end
   end

   // Per-edge operands for the current slot.
   assign is_diag    = (slot_ff == rrec_pkg::SLOT_NW) || (slot_ff == rrec_pkg::SLOT_NE);
   assign sum_c      = rrec_pkg::SUM_W'(s_ff) + rrec_pkg::SUM_W'(nb_ff[slot_ff]);
   assign dividend_c = is_diag ? diag_prod_ff : {1'b0, ts_ff};
   assign prod_c     = PRD_W'(ts_ff) * PRD_W'(rrec_pkg::SQRT2_Q30);

   always_comb begin
      case (slot_ff)
         rrec_pkg::SLOT_NW: to_id_c = up_c_ff;
         rrec_pkg::SLOT_N:  to_id_c = up_c_ff + rrec_pkg::ID_W'(1);
         rrec_pkg::SLOT_NE: to_id_c = up_c_ff + rrec_pkg::ID_W'(2);
         default:           to_id_c = me_c_ff;
      endcase
   end

   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign accept   = req_bus.valid && req_bus.ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rrec_pkg::ST_IDLE: begin
            if (req_bus.valid) state_in = rrec_pkg::ST_READ;
         end
         rrec_pkg::ST_READ: begin
            state_in = rrec_pkg::ST_SETUP;
         end
         rrec_pkg::ST_SETUP: begin
            state_in = (mask_c == '0) ? rrec_pkg::ST_IDLE : rrec_pkg::ST_PICK;
         end
         rrec_pkg::ST_PICK: begin
            if (mask_ff[slot_ff]) begin
               state_in = (sum_c == '0) ? rrec_pkg::ST_EMIT : rrec_pkg::ST_DIV;
            end else if (slot_ff == rrec_pkg::SLOT_W) begin
               state_in = rrec_pkg::ST_IDLE;
            end
         end
         rrec_pkg::ST_DIV: begin
            if (div_done) state_in = rrec_pkg::ST_EMIT;
         end
         rrec_pkg::ST_EMIT: begin
            if (out_free) begin
               state_in = (slot_ff == last_ff) ? rrec_pkg::ST_IDLE : rrec_pkg::ST_PICK;
            end
         end
         default: state_in = rrec_pkg::ST_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_bus.ready = 1'b0;
      div_start     = 1'b0;
      out_load      = 1'b0;
      unique case (state_ff)
         rrec_pkg::ST_IDLE: req_bus.ready = 1'b1;
         rrec_pkg::ST_PICK: div_start = mask_ff[slot_ff] && (sum_c != '0);
         rrec_pkg::ST_EMIT: out_load = out_free;
         default: ;
      endcase
   end

   // Control registers: state, position, history, configuration, output valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rrec_pkg::ST_IDLE;
         slot_ff      <= rrec_pkg::SLOT_NW;
         last_ff      <= rrec_pkg::SLOT_NW;
         mask_ff      <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         left_ff      <= rrec_pkg::NO_ROAD;
         diag_ff      <= rrec_pkg::NO_ROAD;
         num_cols_ff  <= rrec_pkg::NUM_COLUMNS_RST;
         ts_ff        <= rrec_pkg::TIME_SCALE_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;

         // Configuration writes.
         if (csr_wr_en) begin
            unique case (csr_index)
               rrec_pkg::CSR_NUM_COLUMNS: num_cols_ff <= csr_wdata[rrec_pkg::CFG_COLS_W-1:0];
               rrec_pkg::CSR_TIME_SCALE:  ts_ff <= csr_wdata[rrec_pkg::COST_W-1:0];
               default: ;
            endcase
         end

         // Position of the accepted cell: a frame start or a shrunk width restarts it.
         if (accept) begin
            if (req_bus.frame_start) begin
               col_ff <= '0;
               row_ff <= '0;
            end else if ({1'b0, col_ff} >= width_c) begin
               col_ff <= '0;
               row_ff <= row_inc;
            end
         end

         // Latch the edge plan, update the history and step to the next cell.
         if (state_ff == rrec_pkg::ST_SETUP) begin
            mask_ff <= mask_c;
            last_ff <= last_c;
            slot_ff <= rrec_pkg::SLOT_NW;
            diag_ff <= n_rd_ff;
            left_ff <= s_ff;
            if (col_plus1 >= width_c) begin
               col_ff <= '0;
               row_ff <= row_inc;
            end else begin
               col_ff <= col_plus1[rrec_pkg::COL_W-1:0];
            end
         end

         // Skip slots without an edge and advance after each result.
         if (state_ff == rrec_pkg::ST_PICK && !mask_ff[slot_ff]) begin
            slot_ff <= rrec_pkg::edge_slot_type'(slot_ff + 2'd1);
         end
         if (out_load) begin
            slot_ff <= rrec_pkg::edge_slot_type'(slot_ff + 2'd1);
         end

         // Output register valid.
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Line buffer: both neighbor reads together in the read state, the write at setup.
   always_ff @(posedge clock) begin
      if (state_ff == rrec_pkg::ST_READ) begin
         n_rd_ff  <= row_mem[col_ff];
         ne_rd_ff <= row_mem[col_plus1[rrec_pkg::COL_W-1:0]];
      end
      if (state_ff == rrec_pkg::ST_SETUP) begin
         row_mem[col_ff] <= s_ff;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         s_ff     <= req_bus.speed;
         start_ff <= req_bus.frame_start;
      end
      // Row base for the ids of this cell.
      if (state_ff == rrec_pkg::ST_READ) begin
         base_ff <= rrec_pkg::ID_W'(row_ff) * rrec_pkg::ID_W'(width_c);
      end
      // Ids, neighbor speeds and the diagonal dividend.
      if (state_ff == rrec_pkg::ST_SETUP) begin
         me_c_ff      <= base_ff + rrec_pkg::ID_W'(col_ff);
         up_c_ff      <= base_ff - rrec_pkg::ID_W'(width_c) + rrec_pkg::ID_W'(col_ff);
         diag_prod_ff <= prod_c[rrec_pkg::SQRT2_FRAC +: rrec_pkg::DVD_W];
         nb_ff[0]     <= diag_ff;
         nb_ff[1]     <= n_rd_ff;
         nb_ff[2]     <= ne_rd_ff;
         nb_ff[3]     <= left_ff;
      end
      // Cost: saturated for a zero speed sum, otherwise the quotient.
      if (state_ff == rrec_pkg::ST_PICK && mask_ff[slot_ff] && sum_c == '0) begin
         cost_ff <= rrec_pkg::COST_ONES;
      end
      if (state_ff == rrec_pkg::ST_DIV && div_done) begin
         cost_ff <= div_quot;
      end
      // Load the output register.
      if (out_load) begin
         rsp_from_ff <= me_c_ff + rrec_pkg::ID_W'(1);
         rsp_to_ff   <= to_id_c;
         rsp_cost_ff <= cost_ff;
         rsp_last_ff <= (slot_ff == last_ff);
      end
   end

   rrec_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend_c),
      .divisor  (sum_c),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quot)
   );

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.from_id      = rsp_from_ff;
   assign rsp_bus.to_id        = rsp_to_ff;
   assign rsp_bus.cost         = rsp_cost_ff;
   assign rsp_bus.last_of_cell = rsp_last_ff;

`ifndef SYNTHESIS
   a_ready_no_div: assert property (@(posedge clock) disable iff (reset)
      req_bus.ready |-> !div_busy)
      else $error("request channel ready while a division runs");

   a_col_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rrec_pkg::ST_READ) |-> ({1'b0, col_ff} < width_c))
      else $error("column outside the raster width at line buffer read");

   a_last_ends_cell: assert property (@(posedge clock) disable iff (reset)
      (out_load && slot_ff == last_ff) |=> (state_ff == rrec_pkg::ST_IDLE))
      else $error("sequencer kept working after the last edge of a cell");

   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == rrec_pkg::ST_DIV))
      else $error("division finished outside the divide state");

   a_frame_start_seen: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rrec_pkg::ST_READ && start_ff) |-> (col_ff == '0 && row_ff == '0))
      else $error("frame start did not reset the raster position");
`endif

endmodule

[rtl/rrec_div.sv]
// Bit-serial restoring divider for the edge cost.
// Divides a 33-bit dividend by a nonzero 9-bit speed sum, one quotient bit a cycle,
// and saturates quotients that do not fit in 32 bits. Depends on rrec_pkg.
module rrec_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [rrec_pkg::DVD_W-1:0]      dividend,
   input  logic [rrec_pkg::SUM_W-1:0]      divisor,
   output logic                            busy,
   output logic                            done,
   output logic [rrec_pkg::COST_W-1:0]     quotient
);

   localparam int CNT_W = $clog2(rrec_pkg::DVD_W);

   logic [rrec_pkg::DVD_W-1:0] dvd_ff, dvd_in;
   logic [rrec_pkg::SUM_W-1:0] dsr_ff, dsr_in;
   logic [rrec_pkg::SUM_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [rrec_pkg::SUM_W:0]   trial;
   logic                       fits;

   // One restoring step: shift in the next dividend bit and try the subtraction.
   assign trial = {rem_ff, dvd_ff[rrec_pkg::DVD_W-1]};
   assign fits  = (trial >= {1'b0, dsr_ff});

   always_comb begin
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         dvd_in  = dividend;
         dsr_in  = divisor;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? rrec_pkg::SUM_W'(trial - {1'b0, dsr_ff})
                       : trial[rrec_pkg::SUM_W-1:0];
         dvd_in = {dvd_ff[rrec_pkg::DVD_W-2:0], fits};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(rrec_pkg::DVD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
   end

   // The top quotient bit set means the result overflows 32 bits.
   assign quotient = dvd_ff[rrec_pkg::DVD_W-1] ? rrec_pkg::COST_ONES
                                               : dvd_ff[rrec_pkg::COST_W-1:0];
   assign busy     = busy_ff;
   assign done     = done_ff;

`ifndef SYNTHESIS
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider started while busy");

   a_done_follows: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !start && cnt_ff == CNT_W'(rrec_pkg::DVD_W - 1)) |=> done_ff)
      else $error("divider finished without done");

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("divider done while still busy");
`endif

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for raster_road_edge_cost: streams raster cells, predicts the
// graph edges that each road cell yields and compares them with the block's results.
// Depends on rrec_pkg, the channel interfaces in rrec_if and the block's RTL.
module tb;

   localparam int HALF_PERIOD   = 10;
   localparam int RESET_CYCLES  = 11;
   localparam int SETTLE_CYCLES = 200;
   localparam int STALL_LIMIT   = 4000;
   localparam int RANDOM_CELLS  = 440;

   // One graph edge as it leaves the block.
   typedef struct packed {
      logic [rrec_pkg::ID_W-1:0]   from_id;
      logic [rrec_pkg::ID_W-1:0]   to_id;
      logic [rrec_pkg::COST_W-1:0] cost;
      logic                        last_of_cell;
   } road_edge_type;

   // Edge predictor with its own line buffer and register copies.
   class edge_scoreboard_type;
      logic [rrec_pkg::SPEED_W-1:0]    line_buf [rrec_pkg::MAX_COLS];
      logic [rrec_pkg::SPEED_W-1:0]    left_speed;
      logic [rrec_pkg::SPEED_W-1:0]    diag_speed;
      int unsigned                     row_pos;
      int unsigned                     col_pos;
      logic [rrec_pkg::CFG_COLS_W-1:0] num_columns;
      logic [rrec_pkg::COST_W-1:0]     time_scale;
      road_edge_type                   due_edges [$];
      int                              mismatches;

      function new();
         foreach (line_buf[i]) line_buf[i] = '0;
         left_speed  = rrec_pkg::NO_ROAD;
         diag_speed  = rrec_pkg::NO_ROAD;
         row_pos     = 0;
         col_pos     = 0;
         num_columns = rrec_pkg::NUM_COLUMNS_RST;
         time_scale  = rrec_pkg::TIME_SCALE_RST;
         mismatches  = 0;
      endfunction

      function int unsigned clamp_width(logic [rrec_pkg::CFG_COLS_W-1:0] cols);
         if (cols == '0) return 1;
         if (cols > rrec_pkg::CFG_COLS_W'(rrec_pkg::MAX_COLS)) return rrec_pkg::MAX_COLS;
         return 32'(cols);
      endfunction

      function int unsigned width();
         return clamp_width(num_columns);
      endfunction

      function int unsigned pending();
         return due_edges.size();
      endfunction

      function void write_register(rrec_pkg::csr_index_type idx,
                                   logic [rrec_pkg::CSR_DATA_W-1:0] data);
         case (idx)
            rrec_pkg::CSR_NUM_COLUMNS: num_columns = data[rrec_pkg::CFG_COLS_W-1:0];
            rrec_pkg::CSR_TIME_SCALE:  time_scale  = data[rrec_pkg::COST_W-1:0];
            default: ;
         endcase
      endfunction

      function int unsigned next_row(int unsigned r);
         return (r + 1 >= rrec_pkg::MAX_ROWS) ? 0 : r + 1;
      endfunction

      // Cost is the scale over the speed sum; diagonals carry a factor of sqrt(2).
      function logic [rrec_pkg::COST_W-1:0] travel_cost(logic [rrec_pkg::SPEED_W-1:0] a,
                                                         logic [rrec_pkg::SPEED_W-1:0] b,
                                                         logic diag);
         logic [63:0] sum;
         logic [63:0] quot;
         sum = 64'(a) + 64'(b);
         if (sum == 0) return rrec_pkg::COST_ONES;
         if (diag)
            quot = (64'(time_scale) * 64'(rrec_pkg::SQRT2_Q30)) / (sum << rrec_pkg::SQRT2_FRAC);
         else
            quot = 64'(time_scale) / sum;
         return (quot > 64'(rrec_pkg::COST_ONES)) ? rrec_pkg::COST_ONES
                                                  : quot[rrec_pkg::COST_W-1:0];
      endfunction

      function logic [rrec_pkg::ID_W-1:0] cell_number(int unsigned r, int unsigned c,
                                                      int unsigned w);
         logic [63:0] v;
         v = 64'(r) * 64'(w) + 64'(c) + 64'd1;
         return v[rrec_pkg::ID_W-1:0];
      endfunction

      // Work out the edges of one accepted cell request and advance the raster position.
      function void note_request(logic [rrec_pkg::SPEED_W-1:0] spd, logic start);
         int unsigned                  w;
         int unsigned                  r;
         int unsigned                  c;
         logic [rrec_pkg::SPEED_W-1:0] up;
         logic [rrec_pkg::SPEED_W-1:0] up_right;
         logic [rrec_pkg::SPEED_W-1:0] up_left;
         logic [rrec_pkg::ID_W-1:0]    me;
         road_edge_type                found [$];
         w = width();
         if (start) begin
            row_pos = 0;
            col_pos = 0;
         end else if (col_pos >= w) begin
            row_pos = next_row(row_pos);
            col_pos = 0;
         end
         r = row_pos;
         c = col_pos;
         up       = line_buf[c];
         up_right = (c + 1 < w) ? line_buf[c + 1] : rrec_pkg::NO_ROAD;
         up_left  = (c > 0) ? diag_speed : rrec_pkg::NO_ROAD;

         // Neighbors go out in the order north-west, north, north-east, west.
         if (spd != rrec_pkg::NO_ROAD) begin
            me = cell_number(r, c, w);
            if (r > 0) begin
               if (up_left != rrec_pkg::NO_ROAD)
                  found.push_back({me, cell_number(r - 1, c - 1, w),
                                   travel_cost(spd, up_left, 1'b1), 1'b0});
               if (up != rrec_pkg::NO_ROAD)
                  found.push_back({me, cell_number(r - 1, c, w),
                                   travel_cost(spd, up, 1'b0), 1'b0});
               if (up_right != rrec_pkg::NO_ROAD)
                  found.push_back({me, cell_number(r - 1, c + 1, w),
                                   travel_cost(spd, up_right, 1'b1), 1'b0});
            end
            if (c > 0 && left_speed != rrec_pkg::NO_ROAD)
               found.push_back({me, cell_number(r, c - 1, w),
                                travel_cost(spd, left_speed, 1'b0), 1'b0});
            if (found.size() > 0) found[found.size() - 1].last_of_cell = 1'b1;
            foreach (found[i]) due_edges.push_back(found[i]);
         end

         diag_speed  = up;
         line_buf[c] = spd;
         left_speed  = spd;
         col_pos     = c + 1;
         if (col_pos >= w) begin
            col_pos = 0;
            row_pos = next_row(r);
         end
      endfunction

      function void match_field(string field, logic [63:0] want, logic [63:0] got);
         if (want !== got) begin
            $error("%s: expected %0d, actual %0d", field, want, got);
            mismatches++;
         end
      endfunction

      // Compare an accepted edge with the oldest one still due.
      function void check_edge(road_edge_type got);
         road_edge_type want;
         if (due_edges.size() == 0) begin
            $error("edge from %0d to %0d arrived with none due", got.from_id, got.to_id);
            mismatches++;
            return;
         end
         want = due_edges.pop_front();
         match_field("from_id", 64'(want.from_id), 64'(got.from_id));
         match_field("to_id", 64'(want.to_id), 64'(got.to_id));
         match_field("cost", 64'(want.cost), 64'(got.cost));
         match_field("last_of_cell", 64'(want.last_of_cell), 64'(got.last_of_cell));
      endfunction
   endclass

   logic                            clock;
   logic                            reset;
   logic                            csr_wr_en;
   rrec_pkg::csr_index_type         csr_index;
   logic [rrec_pkg::CSR_DATA_W-1:0] csr_wdata;
   logic                            frame_due;
   int                              req_idle_pct;
   int                              rsp_idle_pct;
   int                              stall_cycles = 0;
   edge_scoreboard_type             sb;

   rrec_req_if req_bus();
   rrec_rsp_if rsp_bus();

   raster_road_edge_cost DUT (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #HALF_PERIOD clock = ~clock;

   // The receiver stalls at random at the current rate.
   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   // Register writes, accepted requests and accepted edges feed the scoreboard.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_wr_en) sb.write_register(csr_index, csr_wdata);
         if (req_bus.valid && req_bus.ready) sb.note_request(req_bus.speed, req_bus.frame_start);
         if (rsp_bus.valid && rsp_bus.ready)
            sb.check_edge({rsp_bus.from_id, rsp_bus.to_id, rsp_bus.cost, rsp_bus.last_of_cell});
      end
   end

   // Watchdog: too long without any handshake ends the run.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // A write that widens the raster must be followed by a new frame, or the next row
   // would read line buffer entries that this frame never wrote.
   task automatic write_register(input rrec_pkg::csr_index_type idx,
                                 input logic [rrec_pkg::CSR_DATA_W-1:0] value);
      if (idx == rrec_pkg::CSR_NUM_COLUMNS &&
          sb.clamp_width(value[rrec_pkg::CFG_COLS_W-1:0]) > sb.width())
         frame_due = 1'b1;
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // Offer one cell request after a random gap and hold it until accepted.
   task automatic send_cell(input logic [rrec_pkg::SPEED_W-1:0] spd, input logic start);
      while ($urandom_range(99) < req_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.speed       <= spd;
      req_bus.frame_start <= start | frame_due;
      frame_due = 1'b0;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   // Stop sending until every due edge has come, then let the block go idle.
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [rrec_pkg::SPEED_W-1:0] random_speed();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 22) return rrec_pkg::NO_ROAD;
      if (roll < 27) return 8'd0;
      if (roll < 30) return 8'd254;
      return 8'($urandom_range(253, 1));
   endfunction

   initial begin : stimulus
      logic [rrec_pkg::SPEED_W-1:0]    first_rows [11];
      logic [rrec_pkg::CFG_COLS_W-1:0] cols;
      int unsigned                     count;
      int unsigned                     sent;
      int                              idx;

      sb = new();
      clock               = 1'b0;
      reset               = 1'b1;
      csr_wr_en           = 1'b0;
      csr_index           = rrec_pkg::CSR_NUM_COLUMNS;
      csr_wdata           = '0;
      req_bus.valid       = 1'b0;
      req_bus.speed       = '0;
      req_bus.frame_start = 1'b0;
      frame_due           = 1'b0;
      req_idle_pct        = 31;
      rsp_idle_pct        = 49;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Three columns: every neighbor direction, zero speed sums and full edge sets.
      first_rows = '{8'd10, 8'd255, 8'd0, 8'd0, 8'd254, 8'd7, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
      write_register(rrec_pkg::CSR_NUM_COLUMNS, 32'd3);
      write_register(rrec_pkg::CSR_TIME_SCALE, 32'h0003_0005);
      for (idx = 0; idx < 11; idx++) send_cell(first_rows[idx], idx == 0);
      settle();

      // Width shrinks in the middle of a row, so the next cell opens a new row.
      // The largest scale over a sum of one fits straight, but overflows on a diagonal.
      write_register(rrec_pkg::CSR_NUM_COLUMNS, 32'd2);
      write_register(rrec_pkg::CSR_TIME_SCALE, '1);
      send_cell(8'd1, 1'b0);
      send_cell(8'd0, 1'b0);
      settle();

      // An out-of-range width clamps to the maximum; a zero scale gives zero costs.
      write_register(rrec_pkg::CSR_NUM_COLUMNS, 32'h8000_1FFF);
      write_register(rrec_pkg::CSR_TIME_SCALE, 32'd0);
      send_cell(8'd5, 1'b1);
      send_cell(8'd5, 1'b0);
      send_cell(rrec_pkg::NO_ROAD, 1'b0);
      send_cell(8'd128, 1'b0);
      settle();

      // A zero width clamps to one column, so each cell is a row of its own.
      write_register(rrec_pkg::CSR_NUM_COLUMNS, 32'd0);
      write_register(rrec_pkg::CSR_TIME_SCALE, 32'h0001_0000);
      send_cell(8'd200, 1'b0);
      send_cell(8'd254, 1'b0);
      send_cell(rrec_pkg::NO_ROAD, 1'b0);
      send_cell(8'd3, 1'b0);
      settle();

      // Random frames with mostly small widths, settings changed between them.
      sent = 0;
      while (sent < RANDOM_CELLS) begin
         if (sent < RANDOM_CELLS / 3) begin
            req_idle_pct = 31;
            rsp_idle_pct = 49;
         end else if (sent < 2 * RANDOM_CELLS / 3) begin
            req_idle_pct = 49;
            rsp_idle_pct = 31;
         end else begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         if ($urandom_range(3) != 0) begin
            case ($urandom_range(9))
               0:       cols = '0;
               1:       cols = 13'(rrec_pkg::MAX_COLS);
               2:       cols = 13'($urandom_range(8191, rrec_pkg::MAX_COLS + 1));
               3:       cols = 13'd1;
               4:       cols = 13'($urandom_range(40, 9));
               default: cols = 13'($urandom_range(8, 2));
            endcase
            write_register(rrec_pkg::CSR_NUM_COLUMNS, {19'($urandom), cols});
         end
         if ($urandom_range(3) != 0) begin
            case ($urandom_range(5))
               0:       write_register(rrec_pkg::CSR_TIME_SCALE, '0);
               1:       write_register(rrec_pkg::CSR_TIME_SCALE, '1);
               2:       write_register(rrec_pkg::CSR_TIME_SCALE,
                                       $urandom_range(32'h0004_0000, 1));
               default: write_register(rrec_pkg::CSR_TIME_SCALE, $urandom);
            endcase
         end
         // A frame may carry on across a pause; now and then a frame restarts early.
         count = $urandom_range(40, 12);
         for (idx = 0; idx < count; idx++)
            send_cell(random_speed(),
                      (idx == 0) ? 1'($urandom_range(1)) : ($urandom_range(39) == 0));
         sent += count;
         settle();
      end

      if (sb.mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

[raster_road_edge_cost.f]
rtl/rrec_pkg.sv
rtl/rrec_if.sv
rtl/rrec_div.sv
rtl/raster_road_edge_cost.sv
tb/tb.sv
